// ===== src/disc_pair_elastic_collision_assert.svh =====
// Assertion helpers shared by the collision datapath.
`ifndef DISC_PAIR_ELASTIC_COLLISION_ASSERT_SVH
`define DISC_PAIR_ELASTIC_COLLISION_ASSERT_SVH

// Plain clocked property, disabled while reset is asserted.
`define DPEC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Implication form: antecedent, then consequent.
`define DPEC_IMPLY(label, clk, rst_n, ante, cons, msg) \
	`DPEC_ASSERT(label, clk, rst_n, (ante) |-> cons, msg)

`endif

// ===== src/dpec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dpec_pkg;

	// Register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_X     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Y     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Y     = 3'd4;

	// Divider geometry
	localparam int G_NUM_W = 62;
	localparam int G_DEN_W = 36;
	localparam int F_NUM_W = 49;
	localparam int F_DEN_W = 25;
	localparam int QUO_W   = 26;
	localparam int DIV_LAT = QUO_W + 1;

	localparam int FRONT_STAGES = 8;
	localparam int BACK_STAGES  = 6;
	localparam int LATENCY      = FRONT_STAGES + DIV_LAT + BACK_STAGES;

	typedef struct packed {
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [23:0] vx;
		logic signed [23:0] vy;
		logic [23:0]        r;
	} disc_t;

	typedef struct packed {
		logic  hit;
		logic  degen;
		disc_t a;
		disc_t b;
	} pair_t;

	typedef struct packed {
		logic [19:0]        time_step;
		logic signed [23:0] min_x;
		logic signed [23:0] min_y;
		logic signed [23:0] max_x;
		logic signed [23:0] max_y;
	} cfg_t;

	typedef struct packed {
		logic signed [G_NUM_W-1:0] gx_num;
		logic signed [G_NUM_W-1:0] gy_num;
		logic [G_DEN_W-1:0]        q;
		logic [F_NUM_W-1:0]        f1_num;
		logic [F_NUM_W-1:0]        f2_num;
		logic [F_DEN_W-1:0]        mt;
	} div_op_t;

	function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
		if (v > 32'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -32'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	// round(v / 2^16), ties away from zero
	function automatic logic signed [28:0] rnd_q16(input logic signed [44:0] v);
		logic [44:0] mag;
		logic [44:0] sum;
		mag = v[44] ? 45'(-v) : 45'(v);
		sum = mag + 45'd32768;
		return v[44] ? -$signed({1'b0, sum[43:16]}) : $signed({1'b0, sum[43:16]});
	endfunction

endpackage

`default_nettype wire

// ===== src/disc_pair_elastic_collision.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "disc_pair_elastic_collision_assert.svh"

// Two-disc elastic collision engine, Q7.16 fixed point.
// Input: pulse start with both discs on the first_* / second_* ports; the
//   pair is taken at any clock edge where start is high and busy is low.
//   busy never rises, so one pair can be transferred every cycle.
// Output: done is high for one cycle with hit, degenerate and the new_*
//   fields. There is no backpressure; the receiver must take every result.
// Pipeline: a pair passes through 8 front stages, 27 divider stages and
//   6 back stages between the accepting edge and its result. Throughput is
//   one pair per cycle; the four dividers are fully pipelined,
//   one quotient bit per stage, so they set the depth.
// Configuration: cfg_wr_en/cfg_index/cfg_data write time step and arena
//   walls. Write only while no pair is in flight.
// Reset: arst_n clears all valid bits and loads the default step and arena;
//   items in flight are dropped.
module disc_pair_elastic_collision
	import dpec_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [23:0]          cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [23:0]   first_pos_x,
	input  logic signed [23:0]   first_pos_y,
	input  logic signed [23:0]   first_vel_x,
	input  logic signed [23:0]   first_vel_y,
	input  logic [23:0]          first_mass,
	input  logic [23:0]          first_radius,
	input  logic signed [23:0]   second_pos_x,
	input  logic signed [23:0]   second_pos_y,
	input  logic signed [23:0]   second_vel_x,
	input  logic signed [23:0]   second_vel_y,
	input  logic [23:0]          second_mass,
	input  logic [23:0]          second_radius,
	output logic                 done,
	output logic                 hit,
	output logic                 degenerate,
	output logic signed [23:0]   new_first_pos_x,
	output logic signed [23:0]   new_first_pos_y,
	output logic signed [23:0]   new_first_vel_x,
	output logic signed [23:0]   new_first_vel_y,
	output logic signed [23:0]   new_second_pos_x,
	output logic signed [23:0]   new_second_pos_y,
	output logic signed [23:0]   new_second_vel_x,
	output logic signed [23:0]   new_second_vel_y
);

	// ---------------- configuration registers ----------------
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step <= 20'd1092;
			cfg_q.min_x     <= -24'sd491520;
			cfg_q.min_y     <= -24'sd491520;
			cfg_q.max_x     <= 24'sd491520;
			cfg_q.max_y     <= 24'sd491520;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TIME_STEP: cfg_q.time_step <= cfg_data[19:0];
				REG_MIN_X:     cfg_q.min_x     <= cfg_data;
				REG_MIN_Y:     cfg_q.min_y     <= cfg_data;
				REG_MAX_X:     cfg_q.max_x     <= cfg_data;
				REG_MAX_Y:     cfg_q.max_y     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- input transfer ----------------
	logic  in_vld;
	pair_t in_pair;

	assign busy   = 1'b0;
	assign in_vld = start && !busy;

	assign in_pair.hit    = 1'b0;
	assign in_pair.degen  = 1'b0;
	assign in_pair.a.px   = first_pos_x;
	assign in_pair.a.py   = first_pos_y;
	assign in_pair.a.vx   = first_vel_x;
	assign in_pair.a.vy   = first_vel_y;
	assign in_pair.a.r    = first_radius;
	assign in_pair.b.px   = second_pos_x;
	assign in_pair.b.py   = second_pos_y;
	assign in_pair.b.vx   = second_vel_x;
	assign in_pair.b.vy   = second_vel_y;
	assign in_pair.b.r    = second_radius;

	// ---------------- front: overlap, step back, normal, dot ----------------
	logic    front_vld;
	pair_t   front_pair;
	div_op_t ops;

	dpec_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_vld   (in_vld),
		.in_pair  (in_pair),
		.in_m1    (first_mass),
		.in_m2    (second_mass),
		.out_vld  (front_vld),
		.out_pair (front_pair),
		.ops      (ops)
	);

	// ---------------- dividers ----------------
	// g = round(dot*e / q) per axis, f = round(m * 2^24 / (m1 + m2)) per disc
	logic                  gx_neg, gy_neg;
	logic [G_NUM_W-1:0]    gx_mag, gy_mag;
	logic signed [QUO_W:0] gx, gy, f1, f2;

	assign gx_neg = ops.gx_num[G_NUM_W-1];
	assign gy_neg = ops.gy_num[G_NUM_W-1];
	assign gx_mag = gx_neg ? G_NUM_W'(-ops.gx_num) : G_NUM_W'(ops.gx_num);
	assign gy_mag = gy_neg ? G_NUM_W'(-ops.gy_num) : G_NUM_W'(ops.gy_num);

	dpec_div #(.NUM_W(G_NUM_W), .DEN_W(G_DEN_W), .QUO_W(QUO_W)) u_div_gx (
		.clk (clk), .num_neg (gx_neg), .num_mag (gx_mag), .den (ops.q), .quo (gx)
	);

	dpec_div #(.NUM_W(G_NUM_W), .DEN_W(G_DEN_W), .QUO_W(QUO_W)) u_div_gy (
		.clk (clk), .num_neg (gy_neg), .num_mag (gy_mag), .den (ops.q), .quo (gy)
	);

	dpec_div #(.NUM_W(F_NUM_W), .DEN_W(F_DEN_W), .QUO_W(QUO_W)) u_div_f1 (
		.clk (clk), .num_neg (1'b0), .num_mag (ops.f1_num), .den (ops.mt), .quo (f1)
	);

	dpec_div #(.NUM_W(F_NUM_W), .DEN_W(F_DEN_W), .QUO_W(QUO_W)) u_div_f2 (
		.clk (clk), .num_neg (1'b0), .num_mag (ops.f2_num), .den (ops.mt), .quo (f2)
	);

	// ---------------- side delay matching the dividers ----------------
	logic [DIV_LAT-1:0] dly_vld_q;
	pair_t              dly_pair_q [0:DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_vld_q <= '0;
		end else begin
			dly_vld_q <= {dly_vld_q[DIV_LAT-2:0], front_vld};
		end
	end

	always_ff @(posedge clk) begin
		dly_pair_q[0] <= front_pair;
		for (int i = 1; i < DIV_LAT; i++) begin
			dly_pair_q[i] <= dly_pair_q[i-1];
		end
	end

	// ---------------- back: exchange, forward step, walls ----------------
	logic  out_vld;
	pair_t out_pair;

	dpec_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_vld   (dly_vld_q[DIV_LAT-1]),
		.in_pair  (dly_pair_q[DIV_LAT-1]),
		.gx       (gx),
		.gy       (gy),
		.f1       (f1),
		.f2       (f2),
		.out_vld  (out_vld),
		.out_pair (out_pair)
	);

	// ---------------- result transfer ----------------
	assign done             = out_vld;
	assign hit              = out_pair.hit;
	assign degenerate       = out_pair.degen;
	assign new_first_pos_x  = out_pair.a.px;
	assign new_first_pos_y  = out_pair.a.py;
	assign new_first_vel_x  = out_pair.a.vx;
	assign new_first_vel_y  = out_pair.a.vy;
	assign new_second_pos_x = out_pair.b.px;
	assign new_second_pos_y = out_pair.b.py;
	assign new_second_vel_x = out_pair.b.vx;
	assign new_second_vel_y = out_pair.b.vy;

	// ---------------- checks ----------------
	`DPEC_IMPLY(a_latency, clk, arst_n, start && !busy, ##LATENCY done,
		"result missing after pipeline latency")
	`DPEC_IMPLY(a_degen_hit, clk, arst_n, done && degenerate, hit,
		"degenerate flagged without hit")
	`DPEC_IMPLY(a_miss_pos, clk, arst_n, done && !hit,
		new_first_pos_x == $past(first_pos_x, LATENCY)
		&& new_second_pos_y == $past(second_pos_y, LATENCY),
		"miss changed a position")
	`DPEC_IMPLY(a_miss_vel, clk, arst_n, done && !hit,
		new_first_vel_x == $past(first_vel_x, LATENCY)
		&& new_second_vel_y == $past(second_vel_y, LATENCY),
		"miss changed a velocity")

endmodule

`default_nettype wire

// ===== src/dpec_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, rounds to nearest.
module dpec_div #(
	parameter int NUM_W = 49,
	parameter int DEN_W = 25,
	parameter int QUO_W = 26
) (
	input  logic                    clk,
	input  logic                    num_neg,
	input  logic [NUM_W-1:0]        num_mag,
	input  logic [DEN_W-1:0]        den,
	output logic signed [QUO_W:0]   quo
);

	localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

	logic [REM_W-1:0] rem_s [0:QUO_W-1];
	logic [DEN_W-1:0] den_s [0:QUO_W-1];
	logic [QUO_W-1:0] quo_s [0:QUO_W];
	logic             neg_s [0:QUO_W];

	// stage 0: add half divisor for rounding
	always_ff @(posedge clk) begin
		rem_s[0] <= REM_W'(num_mag) + REM_W'(den >> 1);
		den_s[0] <= den;
		quo_s[0] <= '0;
		neg_s[0] <= num_neg;
	end

	for (genvar i = 1; i <= QUO_W; i++) begin : g_stage
		localparam int K = QUO_W - i;
		logic [REM_W-1:0] dsh;
		logic             ge;

		assign dsh = REM_W'(den_s[i-1]) << K;
		assign ge  = rem_s[i-1] >= dsh;

		always_ff @(posedge clk) begin
			quo_s[i] <= quo_s[i-1] | (ge ? (QUO_W'(1) << K) : '0);
			neg_s[i] <= neg_s[i-1];
		end

		if (i < QUO_W) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[i] <= ge ? rem_s[i-1] - dsh : rem_s[i-1];
				den_s[i] <= den_s[i-1];
			end
		end
	end

	assign quo = neg_s[QUO_W] ? -$signed({1'b0, quo_s[QUO_W]})
	                          : $signed({1'b0, quo_s[QUO_W]});

endmodule

`default_nettype wire

// ===== src/dpec_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Overlap test, step back, normal scaling, dot product and divider operands.
module dpec_front
	import dpec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_vld,
	input  pair_t       in_pair,
	input  logic [23:0] in_m1,
	input  logic [23:0] in_m2,
	output logic        out_vld,
	output pair_t       out_pair,
	output div_op_t     ops
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	pair_t pair_s1, pair_s2, pair_s3, pair_s4, pair_s5, pair_s6, pair_s7, pair_s8;

	// S1
	logic signed [24:0] dx_s1, dy_s1;
	logic [24:0]        sr_s1;
	logic signed [44:0] hax_s1, hay_s1, hbx_s1, hby_s1;
	logic [23:0]        m1_s1, m2_s1;
	// S2
	logic [48:0]        dx2_s2, dy2_s2;
	logic [49:0]        sr2_s2;
	logic signed [23:0] pax_s2, pay_s2, pbx_s2, pby_s2;
	logic [23:0]        m1_s2, m2_s2;
	// S3
	logic [24:0]        ax_s3, ay_s3;
	logic               sx_s3, sy_s3;
	logic signed [24:0] dvx_s3, dvy_s3;
	logic [24:0]        mt_s3;
	logic [23:0]        m1_s3, m2_s3;
	// S4
	logic [4:0]         lead_s4;
	logic [24:0]        ax_s4, ay_s4;
	logic               sx_s4, sy_s4;
	logic signed [24:0] dvx_s4, dvy_s4;
	logic [24:0]        mt_s4;
	logic [23:0]        m1_s4, m2_s4;
	// S5
	logic signed [17:0] ex_s5, ey_s5;
	logic signed [24:0] dvx_s5, dvy_s5;
	logic [24:0]        mt_s5;
	logic [23:0]        m1_s5, m2_s5;
	// S6
	logic signed [42:0] pdx_s6, pdy_s6;
	logic [34:0]        qx_s6, qy_s6;
	logic signed [17:0] ex_s6, ey_s6;
	logic [24:0]        mt_s6;
	logic [23:0]        m1_s6, m2_s6;
	// S7
	logic signed [43:0] dot_s7;
	logic [35:0]        q_s7;
	logic signed [17:0] ex_s7, ey_s7;
	logic [24:0]        mt_s7;
	logic [23:0]        m1_s7, m2_s7;
	// S8
	div_op_t            ops_s8;

	// combinational helpers
	logic signed [49:0] dxsq, dysq;
	logic               hit_c;
	logic signed [24:0] nx_c, ny_c;
	logic [24:0]        mt_c;
	pair_t              pair3_c;
	logic [24:0]        mx_c;
	logic [4:0]         lead_c;
	logic [16:0]        axn_c, ayn_c;
	logic signed [35:0] exsq, eysq;

	always_comb begin
		dxsq  = dx_s1 * dx_s1;
		dysq  = dy_s1 * dy_s1;
		hit_c = ({1'b0, dx2_s2} + {1'b0, dy2_s2}) <= sr2_s2;
		nx_c  = 25'(pbx_s2) - 25'(pax_s2);
		ny_c  = 25'(pby_s2) - 25'(pay_s2);
		mt_c  = 25'(m1_s2) + 25'(m2_s2);
		// non-hit pairs keep their original positions
		pair3_c       = pair_s2;
		pair3_c.hit   = hit_c;
		pair3_c.degen = hit_c && (((nx_c == '0) && (ny_c == '0)) || (mt_c == '0));
		if (hit_c) begin
			pair3_c.a.px = pax_s2;
			pair3_c.a.py = pay_s2;
			pair3_c.b.px = pbx_s2;
			pair3_c.b.py = pby_s2;
		end
		mx_c  = (ax_s3 > ay_s3) ? ax_s3 : ay_s3;
		lead_c = '0;
		for (int i = 0; i < 25; i++) begin
			if (mx_c[i]) begin
				lead_c = 5'(i);
			end
		end
		axn_c = (lead_s4 >= 5'd16) ? 17'(ax_s4 >> (lead_s4 - 5'd16))
		                           : 17'(ax_s4 << (5'd16 - lead_s4));
		ayn_c = (lead_s4 >= 5'd16) ? 17'(ay_s4 >> (lead_s4 - 5'd16))
		                           : 17'(ay_s4 << (5'd16 - lead_s4));
		exsq  = ex_s5 * ex_s5;
		eysq  = ey_s5 * ey_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		// S1: differences, radius sum, step-back products
		pair_s1 <= in_pair;
		dx_s1   <= 25'(in_pair.b.px) - 25'(in_pair.a.px);
		dy_s1   <= 25'(in_pair.b.py) - 25'(in_pair.a.py);
		sr_s1   <= 25'(in_pair.a.r) + 25'(in_pair.b.r);
		hax_s1  <= $signed({1'b0, cfg.time_step}) * in_pair.a.vx;
		hay_s1  <= $signed({1'b0, cfg.time_step}) * in_pair.a.vy;
		hbx_s1  <= $signed({1'b0, cfg.time_step}) * in_pair.b.vx;
		hby_s1  <= $signed({1'b0, cfg.time_step}) * in_pair.b.vy;
		m1_s1   <= in_m1;
		m2_s1   <= in_m2;

		// S2: squares, positions stepped back
		pair_s2 <= pair_s1;
		dx2_s2  <= dxsq[48:0];
		dy2_s2  <= dysq[48:0];
		sr2_s2  <= sr_s1 * sr_s1;
		pax_s2  <= sat24(32'(pair_s1.a.px) - 32'(rnd_q16(hax_s1)));
		pay_s2  <= sat24(32'(pair_s1.a.py) - 32'(rnd_q16(hay_s1)));
		pbx_s2  <= sat24(32'(pair_s1.b.px) - 32'(rnd_q16(hbx_s1)));
		pby_s2  <= sat24(32'(pair_s1.b.py) - 32'(rnd_q16(hby_s1)));
		m1_s2   <= m1_s1;
		m2_s2   <= m2_s1;

		// S3: hit decision
		pair_s3 <= pair3_c;
		ax_s3  <= nx_c[24] ? 25'(-nx_c) : 25'(nx_c);
		ay_s3  <= ny_c[24] ? 25'(-ny_c) : 25'(ny_c);
		sx_s3  <= nx_c[24];
		sy_s3  <= ny_c[24];
		dvx_s3 <= 25'(pair_s2.b.vx) - 25'(pair_s2.a.vx);
		dvy_s3 <= 25'(pair_s2.b.vy) - 25'(pair_s2.a.vy);
		mt_s3  <= mt_c;
		m1_s3  <= m1_s2;
		m2_s3  <= m2_s2;

		// S4: leading one of the larger normal component
		pair_s4 <= pair_s3;
		lead_s4 <= lead_c;
		ax_s4   <= ax_s3;
		ay_s4   <= ay_s3;
		sx_s4   <= sx_s3;
		sy_s4   <= sy_s3;
		dvx_s4  <= dvx_s3;
		dvy_s4  <= dvy_s3;
		mt_s4   <= mt_s3;
		m1_s4   <= m1_s3;
		m2_s4   <= m2_s3;

		// S5: scaled normal, larger component magnitude in [2^16, 2^17)
		pair_s5 <= pair_s4;
		ex_s5   <= sx_s4 ? -$signed({1'b0, axn_c}) : $signed({1'b0, axn_c});
		ey_s5   <= sy_s4 ? -$signed({1'b0, ayn_c}) : $signed({1'b0, ayn_c});
		dvx_s5  <= dvx_s4;
		dvy_s5  <= dvy_s4;
		mt_s5   <= mt_s4;
		m1_s5   <= m1_s4;
		m2_s5   <= m2_s4;

		// S6: partial products
		pair_s6 <= pair_s5;
		pdx_s6  <= dvx_s5 * ex_s5;
		pdy_s6  <= dvy_s5 * ey_s5;
		qx_s6   <= exsq[34:0];
		qy_s6   <= eysq[34:0];
		ex_s6   <= ex_s5;
		ey_s6   <= ey_s5;
		mt_s6   <= mt_s5;
		m1_s6   <= m1_s5;
		m2_s6   <= m2_s5;

		// S7: dot and norm
		pair_s7 <= pair_s6;
		dot_s7  <= 44'(pdx_s6) + 44'(pdy_s6);
		q_s7    <= 36'(qx_s6) + 36'(qy_s6);
		ex_s7   <= ex_s6;
		ey_s7   <= ey_s6;
		mt_s7   <= mt_s6;
		m1_s7   <= m1_s6;
		m2_s7   <= m2_s6;

		// S8: divider operands
		pair_s8       <= pair_s7;
		ops_s8.gx_num <= dot_s7 * ex_s7;
		ops_s8.gy_num <= dot_s7 * ey_s7;
		ops_s8.q      <= q_s7;
		ops_s8.f1_num <= {1'b0, m1_s7, 24'd0};
		ops_s8.f2_num <= {1'b0, m2_s7, 24'd0};
		ops_s8.mt     <= mt_s7;
	end

	assign out_vld  = vld_s8;
	assign out_pair = pair_s8;
	assign ops      = ops_s8;

endmodule

`default_nettype wire

// ===== src/dpec_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Velocity exchange, forward step and wall reflection.
module dpec_back
	import dpec_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_vld,
	input  pair_t              in_pair,
	input  logic signed [QUO_W:0] gx,
	input  logic signed [QUO_W:0] gy,
	input  logic signed [QUO_W:0] f1,
	input  logic signed [QUO_W:0] f2,
	output logic               out_vld,
	output pair_t              out_pair
);

	localparam int PW = 2 * (QUO_W + 1);

	function automatic logic signed [31:0] rnd_q23(input logic signed [PW-1:0] v);
		logic [PW-1:0] mag;
		logic [PW-1:0] sum;
		mag = v[PW-1] ? PW'(-v) : PW'(v);
		sum = mag + PW'(23'h400000);
		return v[PW-1] ? -32'(sum[PW-1:23]) : 32'(sum[PW-1:23]);
	endfunction

	function automatic logic signed [23:0] neg_sat(input logic signed [23:0] v);
		return (v == 24'sh800000) ? 24'sh7FFFFF : -v;
	endfunction

	// left, then bottom
	function automatic disc_t wall_lo(input disc_t d, input logic signed [23:0] mnx,
	                                  input logic signed [23:0] mny);
		disc_t o;
		logic signed [25:0] rr;
		logic signed [27:0] r2;
		o  = d;
		rr = $signed({2'b00, d.r});
		r2 = $signed({4'b0000, d.r});
		if (26'(d.px) - rr < 26'(mnx)) begin
			o.px = sat24(32'(28'(mnx) + 28'(mnx) - 28'(d.px) + r2 + r2));
			o.vx = neg_sat(d.vx);
		end
		if (26'(d.py) - rr < 26'(mny)) begin
			o.py = sat24(32'(28'(mny) + 28'(mny) - 28'(d.py) + r2 + r2));
			o.vy = neg_sat(d.vy);
		end
		return o;
	endfunction

	// right, then top
	function automatic disc_t wall_hi(input disc_t d, input logic signed [23:0] mxx,
	                                  input logic signed [23:0] mxy);
		disc_t o;
		logic signed [25:0] rr;
		logic signed [27:0] r2;
		o  = d;
		rr = $signed({2'b00, d.r});
		r2 = $signed({4'b0000, d.r});
		if (26'(d.px) + rr > 26'(mxx)) begin
			o.px = sat24(32'(28'(mxx) + 28'(mxx) - 28'(d.px) - r2 - r2));
			o.vx = neg_sat(d.vx);
		end
		if (26'(d.py) + rr > 26'(mxy)) begin
			o.py = sat24(32'(28'(mxy) + 28'(mxy) - 28'(d.py) - r2 - r2));
			o.vy = neg_sat(d.vy);
		end
		return o;
	endfunction

	logic vld_b1, vld_b2, vld_b3, vld_b4, vld_b5, vld_b6;
	pair_t pair_b1, pair_b2, pair_b3, pair_b4, pair_b5, pair_b6;
	logic signed [PW-1:0] gx2_b1, gy2_b1, gx1_b1, gy1_b1;
	logic signed [44:0]   hax_b3, hay_b3, hbx_b3, hby_b3;
	logic                 upd;
	pair_t                pair2_c, pair4_c, pair5_c, pair6_c;

	assign upd = pair_b1.hit && !pair_b1.degen;

	always_comb begin
		// velocity exchange
		pair2_c = pair_b1;
		if (upd) begin
			pair2_c.a.vx = sat24(32'(pair_b1.a.vx) + rnd_q23(gx2_b1));
			pair2_c.a.vy = sat24(32'(pair_b1.a.vy) + rnd_q23(gy2_b1));
			pair2_c.b.vx = sat24(32'(pair_b1.b.vx) - rnd_q23(gx1_b1));
			pair2_c.b.vy = sat24(32'(pair_b1.b.vy) - rnd_q23(gy1_b1));
		end
		// forward step
		pair4_c = pair_b3;
		if (pair_b3.hit) begin
			pair4_c.a.px = sat24(32'(pair_b3.a.px) + 32'(rnd_q16(hax_b3)));
			pair4_c.a.py = sat24(32'(pair_b3.a.py) + 32'(rnd_q16(hay_b3)));
			pair4_c.b.px = sat24(32'(pair_b3.b.px) + 32'(rnd_q16(hbx_b3)));
			pair4_c.b.py = sat24(32'(pair_b3.b.py) + 32'(rnd_q16(hby_b3)));
		end
		// walls
		pair5_c = pair_b4;
		if (pair_b4.hit) begin
			pair5_c.a = wall_lo(pair_b4.a, cfg.min_x, cfg.min_y);
			pair5_c.b = wall_lo(pair_b4.b, cfg.min_x, cfg.min_y);
		end
		pair6_c = pair_b5;
		if (pair_b5.hit) begin
			pair6_c.a = wall_hi(pair_b5.a, cfg.max_x, cfg.max_y);
			pair6_c.b = wall_hi(pair_b5.b, cfg.max_x, cfg.max_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_b1 <= 1'b0;
			vld_b2 <= 1'b0;
			vld_b3 <= 1'b0;
			vld_b4 <= 1'b0;
			vld_b5 <= 1'b0;
			vld_b6 <= 1'b0;
		end else begin
			vld_b1 <= in_vld;
			vld_b2 <= vld_b1;
			vld_b3 <= vld_b2;
			vld_b4 <= vld_b3;
			vld_b5 <= vld_b4;
			vld_b6 <= vld_b5;
		end
	end

	always_ff @(posedge clk) begin
		// B1: impulse products
		pair_b1 <= in_pair;
		gx2_b1  <= gx * f2;
		gy2_b1  <= gy * f2;
		gx1_b1  <= gx * f1;
		gy1_b1  <= gy * f1;

		// B2: velocity exchange
		pair_b2 <= pair2_c;

		// B3: forward-step products
		pair_b3 <= pair_b2;
		hax_b3  <= $signed({1'b0, cfg.time_step}) * pair_b2.a.vx;
		hay_b3  <= $signed({1'b0, cfg.time_step}) * pair_b2.a.vy;
		hbx_b3  <= $signed({1'b0, cfg.time_step}) * pair_b2.b.vx;
		hby_b3  <= $signed({1'b0, cfg.time_step}) * pair_b2.b.vy;

		// B4: forward step
		pair_b4 <= pair4_c;

		// B5, B6: walls
		pair_b5 <= pair5_c;
		pair_b6 <= pair6_c;
	end

	assign out_vld  = vld_b6;
	assign out_pair = pair_b6;

endmodule

`default_nettype wire
